@@ design/cfa_pkg.sv @@
package cfa_pkg;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } t_fit;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_OWNER = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_FIT_MODE = 2'd0,
        REG_MEM_SIZE = 2'd1,
        REG_RESERVED = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_REPLY
    } t_state;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_SCAN,
        CMD_APPLY,
        CMD_INIT
    } t_cmd;

endpackage

@@ design/contiguous_fit_allocator.sv @@
// Contiguous-fit allocator over a table of free holes.
// Command channel: i_start with i_op, i_owner_id, i_req_units is taken when
// o_busy is low. Each command gives one result word on o_status and
// o_base_addr, marked by o_done for one cycle; the receiver cannot stall it.
// Allocate picks a hole by fit mode (first, next, best, worst, ties to the
// lowest address) and cuts the span from its bottom. Free returns the owner's
// span and merges it with adjacent holes.
// Flow: the hole table is a row of cells with the search token registered
// every four cells. A command passes from idle through look, scan, decide and
// apply to the result word; next fit with wrap scans again after decide. A
// command refused on owner or zero size goes from look straight to reply.
// One command is in work at a time; o_busy falls in the cycle o_done is high,
// so the next command can be taken at the edge that takes the result word.
// Config channel (i_cfg_valid/o_cfg_ready, index, data) is ready while idle
// and i_start is low. Writing memory_size or reserved_units rebuilds the hole
// table, clears all owners and resets the next-fit cursor; owner records are
// held in a memory and tracked by valid flags, so no clearing pass is needed.
// Reset: fit mode first fit, 2048 units, 80 reserved, one hole.
module contiguous_fit_allocator #(
    parameter int MAX_UNITS  = 2048,
    parameter int MAX_HOLES  = 32,
    parameter int NUM_OWNERS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_op,
    input  logic [7:0]                        i_owner_id,
    input  logic [11:0]                       i_req_units,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [10:0]                       o_base_addr,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [11:0]                       i_cfg_data
);
    import cfa_pkg::*;

    localparam int AW  = 11;
    localparam int LW  = 12;
    localparam int IW  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int OW  = $clog2(NUM_OWNERS);
    localparam int SEG = 4;
    localparam int NSCAN = (MAX_HOLES + SEG - 1) / SEG;
    localparam int CW  = $clog2(NSCAN + 1);
    localparam logic [LW:0] MAXU = (MAX_UNITS > 2048) ? (LW+1)'(2048) : (LW+1)'(MAX_UNITS);

    t_state        r_state, n_state;
    logic [1:0]    r_mode;
    logic [LW-1:0] r_msize;
    logic [AW-1:0] r_resv;
    logic [AW-1:0] r_cursor;
    logic          r_op;
    logic [7:0]    r_owner;
    logic [LW-1:0] r_req;
    logic          r_bounded;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_status;
    logic [AW-1:0] r_base;
    logic          r_done;
    logic          r_ovalid_rd;
    logic [AW-1:0] r_fbase;
    logic [LW-1:0] r_flen;
    logic [NUM_OWNERS-1:0] r_ovalid;
    logic [AW-1:0] r_obase_mem [NUM_OWNERS];
    logic [LW-1:0] r_olen_mem [NUM_OWNERS];
    // decide results
    logic          r_pk_v, r_bl_v, r_ab_v, r_sp_v;
    logic [IW-1:0] r_pk_idx, r_bl_idx, r_ab_idx, r_sp_idx;
    logic [AW-1:0] r_pk_start;
    logic [LW-1:0] r_pk_len;

    t_cmd          cmd;
    logic          first;
    logic [LW-1:0] top;
    logic          init_valid;
    logic          cfg_wr;
    logic          do_init;

    logic            c_pk_v, c_bl_v, c_ab_v, c_sp_v;
    logic [IW-1:0]   c_pk_idx, c_bl_idx, c_ab_idx, c_sp_idx;
    logic [AW-1:0]   c_pk_start;
    logic [LW-1:0]   c_pk_len;
    logic [AW-1:0]   h_start [MAX_HOLES];
    logic [LW-1:0]   h_len [MAX_HOLES];
    logic [MAX_HOLES-1:0] wr_en, wr_valid;
    logic [AW-1:0]   wr_start [MAX_HOLES];
    logic [LW-1:0]   wr_len [MAX_HOLES];
    logic [AW:0]     fend;
    logic            owner_ok;
    logic            free_ok;
    logic            alloc_ok;
    logic            apply_en;
    logic [LW-1:0]   new_msize;
    logic [AW-1:0]   new_resv;

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign do_init     = cfg_wr && (i_cfg_index == REG_MEM_SIZE || i_cfg_index == REG_RESERVED);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_base_addr = r_base;
    assign fend        = {1'b0, r_fbase} + r_flen[AW:0];
    assign owner_ok    = ({1'b0, r_owner} < (9)'(NUM_OWNERS));

    // init values from the registers about to take effect, reset geometry in reset
    always_comb begin
        new_msize = r_msize;
        new_resv  = r_resv;
        if (cfg_wr && i_cfg_index == REG_MEM_SIZE) new_msize = i_cfg_data;
        if (cfg_wr && i_cfg_index == REG_RESERVED) new_resv = i_cfg_data[AW-1:0];
        if (!i_rst_n) begin
            new_msize = LW'(2048);
            new_resv  = AW'(80);
        end
        top = ({1'b0, new_msize} > MAXU) ? MAXU[LW-1:0] : new_msize;
        init_valid = {1'b0, new_resv} < top;
    end

    always_comb begin
        unique case (r_state)
            S_SCAN:  cmd = CMD_SCAN;
            S_APPLY: cmd = CMD_APPLY;
            default: cmd = do_init ? CMD_INIT : CMD_NONE;
        endcase
    end

    assign first = (r_cnt == '0);

    cfa_chain #(.AW(AW), .LW(LW), .NH(MAX_HOLES), .IW(IW), .SEG(SEG)) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_first      (first),
        .i_mode       (r_mode),
        .i_bounded    (r_bounded),
        .i_is_free    (r_op == OP_FREE),
        .i_cursor     (r_cursor),
        .i_req        (r_req),
        .i_fbase      (r_fbase),
        .i_fend       (fend),
        .i_init_start (new_resv),
        .i_init_len   (top - LW'(new_resv)),
        .i_init_valid (init_valid),
        .i_wr_en      (wr_en),
        .i_wr_valid   (wr_valid),
        .i_wr_start   (wr_start),
        .i_wr_len     (wr_len),
        .o_pk_v       (c_pk_v),
        .o_pk_idx     (c_pk_idx),
        .o_pk_start   (c_pk_start),
        .o_pk_len     (c_pk_len),
        .o_bl_v       (c_bl_v),
        .o_bl_idx     (c_bl_idx),
        .o_ab_v       (c_ab_v),
        .o_ab_idx     (c_ab_idx),
        .o_sp_v       (c_sp_v),
        .o_sp_idx     (c_sp_idx),
        .o_start      (h_start),
        .o_len        (h_len)
    );

    assign alloc_ok = r_pk_v;
    assign free_ok  = r_bl_v || r_ab_v || r_sp_v;
    assign apply_en = (r_op == OP_ALLOC) ? alloc_ok : free_ok;

    // hole writes in the apply cycle
    always_comb begin
        for (int k = 0; k < MAX_HOLES; k++) begin
            wr_en[k]    = 1'b0;
            wr_valid[k] = 1'b1;
            wr_start[k] = h_start[k];
            wr_len[k]   = h_len[k];
        end
        if (r_op == OP_ALLOC) begin
            if (alloc_ok) begin
                wr_en[r_pk_idx] = 1'b1;
                if (r_pk_len == r_req) begin
                    wr_valid[r_pk_idx] = 1'b0;
                end else begin
                    wr_start[r_pk_idx] = r_pk_start + r_req[AW-1:0];
                    wr_len[r_pk_idx]   = r_pk_len - r_req;
                end
            end
        end else begin
            priority if (r_bl_v && r_ab_v) begin
                wr_en[r_bl_idx] = 1'b1;
                wr_len[r_bl_idx] = h_len[r_bl_idx] + r_flen + h_len[r_ab_idx];
                wr_en[r_ab_idx] = 1'b1;
                wr_valid[r_ab_idx] = 1'b0;
            end else if (r_bl_v) begin
                wr_en[r_bl_idx] = 1'b1;
                wr_len[r_bl_idx] = h_len[r_bl_idx] + r_flen;
            end else if (r_ab_v) begin
                wr_en[r_ab_idx] = 1'b1;
                wr_start[r_ab_idx] = r_fbase;
                wr_len[r_ab_idx] = h_len[r_ab_idx] + r_flen;
            end else if (r_sp_v) begin
                wr_en[r_sp_idx] = 1'b1;
                wr_start[r_sp_idx] = r_fbase;
                wr_len[r_sp_idx] = r_flen;
            end else begin
                wr_en[0] = 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !do_init) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (!owner_ok) begin
                    n_state = S_REPLY;
                end else if (r_op == OP_ALLOC) begin
                    n_state = (r_ovalid_rd || r_req == '0) ? S_REPLY : S_SCAN;
                end else begin
                    n_state = r_ovalid_rd ? S_SCAN : S_REPLY;
                end
            end
            S_SCAN: begin
                if (r_cnt == CW'(NSCAN - 1)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_op == OP_ALLOC && r_mode == FIT_NEXT && r_bounded && !r_pk_v) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: n_state = S_IDLE;
            S_REPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_mode   <= FIT_FIRST;
            r_msize  <= LW'(2048);
            r_resv   <= AW'(80);
            r_cursor <= AW'(79);
            r_ovalid <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (cfg_wr) begin
                unique case (t_reg'(i_cfg_index))
                    REG_FIT_MODE: r_mode <= i_cfg_data[1:0];
                    REG_MEM_SIZE: r_msize <= i_cfg_data;
                    REG_RESERVED: r_resv <= i_cfg_data[AW-1:0];
                    default: ;
                endcase
            end
            if (do_init) begin
                r_ovalid <= '0;
                r_cursor <= new_resv - AW'(1);
            end
            if (r_state == S_SCAN) begin
                r_cnt <= (r_cnt == CW'(NSCAN - 1)) ? '0 : r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_REPLY) r_done <= 1'b1;
            if (r_state == S_APPLY) begin
                r_done <= 1'b1;
                if (r_op == OP_ALLOC) begin
                    if (alloc_ok) begin
                        r_ovalid[r_owner[OW-1:0]] <= 1'b1;
                        if (r_mode == FIT_NEXT) r_cursor <= r_pk_start;
                    end else if (r_mode == FIT_NEXT) begin
                        r_cursor <= r_resv - AW'(1);
                    end
                end else if (free_ok) begin
                    r_ovalid[r_owner[OW-1:0]] <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op      <= i_op;
            r_owner   <= i_owner_id;
            r_req     <= i_req_units;
            r_bounded <= (r_mode == FIT_NEXT);
            r_ovalid_rd <= r_ovalid[i_owner_id[OW-1:0]];
        end
        if (r_state == S_LOOK) begin
            r_fbase <= r_obase_mem[r_owner[OW-1:0]];
            r_flen  <= r_olen_mem[r_owner[OW-1:0]];
        end
        if (r_state == S_SCAN && r_cnt == CW'(NSCAN - 1)) begin
            r_pk_v     <= c_pk_v;
            r_pk_idx   <= c_pk_idx;
            r_pk_start <= c_pk_start;
            r_pk_len   <= c_pk_len;
            r_bl_v     <= c_bl_v;
            r_bl_idx   <= c_bl_idx;
            r_ab_v     <= c_ab_v;
            r_ab_idx   <= c_ab_idx;
            r_sp_v     <= c_sp_v;
            r_sp_idx   <= c_sp_idx;
        end
        if (r_state == S_DECIDE) r_bounded <= 1'b0;
        if (r_state == S_APPLY && r_op == OP_ALLOC && alloc_ok) begin
            r_obase_mem[r_owner[OW-1:0]] <= r_pk_start;
            r_olen_mem[r_owner[OW-1:0]]  <= r_req;
        end
        if (r_state == S_REPLY) begin
            r_base <= '0;
            priority if (!owner_ok) begin
                r_status <= ST_OWNER;
            end else if (r_op == OP_ALLOC && r_ovalid_rd) begin
                r_status <= ST_OWNER;
            end else if (r_op == OP_FREE) begin
                r_status <= ST_OWNER;
            end else begin
                r_status <= ST_NOFIT;
            end
        end
        if (r_state == S_APPLY) begin
            r_status <= apply_en ? ST_DONE : ST_NOFIT;
            r_base   <= !apply_en ? '0 : (r_op == OP_ALLOC) ? r_pk_start : r_fbase;
        end
    end
endmodule

@@ design/cfa_cell.sv @@
// One hole table entry. Compares itself against the search token coming from the
// previous cell, updates the token and forwards it to the next cell.
module cfa_cell #(
    parameter int AW = 11,
    parameter int LW = 12,
    parameter int IW = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IW-1:0]        i_my_idx,
    input  cfa_pkg::t_cmd        i_cmd,
    input  logic [1:0]           i_mode,
    input  logic                 i_bounded,
    input  logic                 i_is_free,
    input  logic [AW-1:0]        i_cursor,
    input  logic [LW-1:0]        i_req,
    input  logic [AW-1:0]        i_fbase,
    input  logic [AW:0]          i_fend,
    input  logic [AW-1:0]        i_init_start,
    input  logic [LW-1:0]        i_init_len,
    input  logic                 i_init_valid,
    // apply commands
    input  logic                 i_wr_en,
    input  logic                 i_wr_valid,
    input  logic [AW-1:0]        i_wr_start,
    input  logic [LW-1:0]        i_wr_len,
    // token in
    input  logic                 i_pk_v,
    input  logic [IW-1:0]        i_pk_idx,
    input  logic [AW-1:0]        i_pk_start,
    input  logic [LW-1:0]        i_pk_len,
    input  logic                 i_bl_v,
    input  logic [IW-1:0]        i_bl_idx,
    input  logic                 i_ab_v,
    input  logic [IW-1:0]        i_ab_idx,
    input  logic                 i_sp_v,
    input  logic [IW-1:0]        i_sp_idx,
    // token out
    output logic                 o_pk_v,
    output logic [IW-1:0]        o_pk_idx,
    output logic [AW-1:0]        o_pk_start,
    output logic [LW-1:0]        o_pk_len,
    output logic                 o_bl_v,
    output logic [IW-1:0]        o_bl_idx,
    output logic                 o_ab_v,
    output logic [IW-1:0]        o_ab_idx,
    output logic                 o_sp_v,
    output logic [IW-1:0]        o_sp_idx,
    output logic [AW-1:0]        o_start,
    output logic [LW-1:0]        o_len
);
    import cfa_pkg::*;

    logic          r_valid;
    logic [AW-1:0] r_start;
    logic [LW-1:0] r_len;
    logic          cand;
    logic          better;
    logic          is_bl;
    logic [AW:0]   hend;

    assign o_start = r_start;
    assign o_len   = r_len;
    assign hend    = {1'b0, r_start} + r_len[AW:0];

    always_comb begin
        cand = r_valid && (r_len >= i_req) && !(i_bounded && (r_start <= i_cursor));
        better = 1'b0;
        if (cand) begin
            if (!i_pk_v) begin
                better = 1'b1;
            end else begin
                unique case (t_fit'(i_mode))
                    FIT_BEST: better = (r_len < i_pk_len) ||
                                       (r_len == i_pk_len && r_start < i_pk_start);
                    FIT_WORST: better = (r_len > i_pk_len) ||
                                        (r_len == i_pk_len && r_start < i_pk_start);
                    default: better = r_start < i_pk_start;
                endcase
            end
        end
        o_pk_v     = i_pk_v || better;
        o_pk_idx   = better ? i_my_idx : i_pk_idx;
        o_pk_start = better ? r_start : i_pk_start;
        o_pk_len   = better ? r_len : i_pk_len;
        is_bl  = i_is_free && r_valid && !i_bl_v && (hend == {1'b0, i_fbase});
        o_bl_v   = i_bl_v || is_bl;
        o_bl_idx = is_bl ? i_my_idx : i_bl_idx;
        o_ab_v   = i_ab_v || (i_is_free && r_valid && !is_bl && !i_ab_v &&
                              ({1'b0, r_start} == i_fend));
        o_ab_idx = (o_ab_v && !i_ab_v) ? i_my_idx : i_ab_idx;
        o_sp_v   = i_sp_v || !r_valid;
        o_sp_idx = (!r_valid && !i_sp_v) ? i_my_idx : i_sp_idx;
    end

    // reset loads the init values, which the top level holds at the reset geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd == CMD_INIT) begin
            r_valid <= i_init_valid;
        end else if (i_cmd == CMD_APPLY && i_wr_en) begin
            r_valid <= i_wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd == CMD_INIT) begin
            r_start <= i_init_start;
            r_len   <= i_init_len;
        end else if (i_cmd == CMD_APPLY && i_wr_en) begin
            r_start <= i_wr_start;
            r_len   <= i_wr_len;
        end
    end
endmodule

@@ design/cfa_chain.sv @@
// Row of hole cells with a registered token between groups of cells.
module cfa_chain #(
    parameter int AW = 11,
    parameter int LW = 12,
    parameter int NH = 32,
    parameter int IW = 5,
    parameter int SEG = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cfa_pkg::t_cmd   i_cmd,
    input  logic            i_first,
    input  logic [1:0]      i_mode,
    input  logic            i_bounded,
    input  logic            i_is_free,
    input  logic [AW-1:0]   i_cursor,
    input  logic [LW-1:0]   i_req,
    input  logic [AW-1:0]   i_fbase,
    input  logic [AW:0]     i_fend,
    input  logic [AW-1:0]   i_init_start,
    input  logic [LW-1:0]   i_init_len,
    input  logic            i_init_valid,
    input  logic [NH-1:0]   i_wr_en,
    input  logic [NH-1:0]   i_wr_valid,
    input  logic [AW-1:0]   i_wr_start [NH],
    input  logic [LW-1:0]   i_wr_len [NH],
    output logic            o_pk_v,
    output logic [IW-1:0]   o_pk_idx,
    output logic [AW-1:0]   o_pk_start,
    output logic [LW-1:0]   o_pk_len,
    output logic            o_bl_v,
    output logic [IW-1:0]   o_bl_idx,
    output logic            o_ab_v,
    output logic [IW-1:0]   o_ab_idx,
    output logic            o_sp_v,
    output logic [IW-1:0]   o_sp_idx,
    output logic [AW-1:0]   o_start [NH],
    output logic [LW-1:0]   o_len [NH]
);
    import cfa_pkg::*;

    logic            pk_v [NH+1];
    logic [IW-1:0]   pk_idx [NH+1];
    logic [AW-1:0]   pk_start [NH+1];
    logic [LW-1:0]   pk_len [NH+1];
    logic            bl_v [NH+1];
    logic [IW-1:0]   bl_idx [NH+1];
    logic            ab_v [NH+1];
    logic [IW-1:0]   ab_idx [NH+1];
    logic            sp_v [NH+1];
    logic [IW-1:0]   sp_idx [NH+1];

    logic            r_pk_v [NH];
    logic [IW-1:0]   r_pk_idx [NH];
    logic [AW-1:0]   r_pk_start [NH];
    logic [LW-1:0]   r_pk_len [NH];
    logic            r_bl_v [NH];
    logic [IW-1:0]   r_bl_idx [NH];
    logic            r_ab_v [NH];
    logic [IW-1:0]   r_ab_idx [NH];
    logic            r_sp_v [NH];
    logic [IW-1:0]   r_sp_idx [NH];

    assign pk_v[0] = 1'b0;
    assign pk_idx[0] = '0;
    assign pk_start[0] = '0;
    assign pk_len[0] = '0;
    assign bl_v[0] = 1'b0;
    assign bl_idx[0] = '0;
    assign ab_v[0] = 1'b0;
    assign ab_idx[0] = '0;
    assign sp_v[0] = 1'b0;
    assign sp_idx[0] = '0;

    // token registered every SEG cells
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NH; k++) begin
            r_pk_v[k]     <= pk_v[k+1];
            r_pk_idx[k]   <= pk_idx[k+1];
            r_pk_start[k] <= pk_start[k+1];
            r_pk_len[k]   <= pk_len[k+1];
            r_bl_v[k]     <= bl_v[k+1];
            r_bl_idx[k]   <= bl_idx[k+1];
            r_ab_v[k]     <= ab_v[k+1];
            r_ab_idx[k]   <= ab_idx[k+1];
            r_sp_v[k]     <= sp_v[k+1];
            r_sp_idx[k]   <= sp_idx[k+1];
        end
    end

    for (genvar g = 0; g < NH; g++) begin : g_cell
        logic          in_pk_v, in_bl_v, in_ab_v, in_sp_v;
        logic [IW-1:0] in_pk_idx, in_bl_idx, in_ab_idx, in_sp_idx;
        logic [AW-1:0] in_pk_start;
        logic [LW-1:0] in_pk_len;
        if (g > 0 && (g % SEG) == 0) begin : g_reg
            assign in_pk_v     = r_pk_v[g-1] && !i_first;
            assign in_pk_idx   = r_pk_idx[g-1];
            assign in_pk_start = r_pk_start[g-1];
            assign in_pk_len   = r_pk_len[g-1];
            assign in_bl_v     = r_bl_v[g-1] && !i_first;
            assign in_bl_idx   = r_bl_idx[g-1];
            assign in_ab_v     = r_ab_v[g-1] && !i_first;
            assign in_ab_idx   = r_ab_idx[g-1];
            assign in_sp_v     = r_sp_v[g-1] && !i_first;
            assign in_sp_idx   = r_sp_idx[g-1];
        end else begin : g_comb
            assign in_pk_v     = pk_v[g];
            assign in_pk_idx   = pk_idx[g];
            assign in_pk_start = pk_start[g];
            assign in_pk_len   = pk_len[g];
            assign in_bl_v     = bl_v[g];
            assign in_bl_idx   = bl_idx[g];
            assign in_ab_v     = ab_v[g];
            assign in_ab_idx   = ab_idx[g];
            assign in_sp_v     = sp_v[g];
            assign in_sp_idx   = sp_idx[g];
        end
        cfa_cell #(.AW(AW), .LW(LW), .IW(IW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_my_idx     (IW'(g)),
            .i_cmd        (i_cmd),
            .i_mode       (i_mode),
            .i_bounded    (i_bounded),
            .i_is_free    (i_is_free),
            .i_cursor     (i_cursor),
            .i_req        (i_req),
            .i_fbase      (i_fbase),
            .i_fend       (i_fend),
            .i_init_start (i_init_start),
            .i_init_len   (g == 0 ? i_init_len : LW'(0)),
            .i_init_valid (g == 0 ? i_init_valid : 1'b0),
            .i_wr_en      (i_wr_en[g]),
            .i_wr_valid   (i_wr_valid[g]),
            .i_wr_start   (i_wr_start[g]),
            .i_wr_len     (i_wr_len[g]),
            .i_pk_v       (in_pk_v),
            .i_pk_idx     (in_pk_idx),
            .i_pk_start   (in_pk_start),
            .i_pk_len     (in_pk_len),
            .i_bl_v       (in_bl_v),
            .i_bl_idx     (in_bl_idx),
            .i_ab_v       (in_ab_v),
            .i_ab_idx     (in_ab_idx),
            .i_sp_v       (in_sp_v),
            .i_sp_idx     (in_sp_idx),
            .o_pk_v       (pk_v[g+1]),
            .o_pk_idx     (pk_idx[g+1]),
            .o_pk_start   (pk_start[g+1]),
            .o_pk_len     (pk_len[g+1]),
            .o_bl_v       (bl_v[g+1]),
            .o_bl_idx     (bl_idx[g+1]),
            .o_ab_v       (ab_v[g+1]),
            .o_ab_idx     (ab_idx[g+1]),
            .o_sp_v       (sp_v[g+1]),
            .o_sp_idx     (sp_idx[g+1]),
            .o_start      (o_start[g]),
            .o_len        (o_len[g])
        );
    end

    assign o_pk_v     = pk_v[NH];
    assign o_pk_idx   = pk_idx[NH];
    assign o_pk_start = pk_start[NH];
    assign o_pk_len   = pk_len[NH];
    assign o_bl_v     = bl_v[NH];
    assign o_bl_idx   = bl_idx[NH];
    assign o_ab_v     = ab_v[NH];
    assign o_ab_idx   = ab_idx[NH];
    assign o_sp_v     = sp_v[NH];
    assign o_sp_idx   = sp_idx[NH];
endmodule
